// ----- design/sobel_horizontal_gradient_macros.svh -----
// ----------------------------------------------------------------------------
// Sobel horizontal gradient assertion macros
// Shared concurrent assertion forms used by the gradient block.
// ----------------------------------------------------------------------------
`ifndef SOBEL_HORIZONTAL_GRADIENT_MACROS_SVH
`define SOBEL_HORIZONTAL_GRADIENT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SOBH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SOBH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/sobh_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel horizontal gradient package
// Types, register codes and reset values shared by the gradient block.
// ----------------------------------------------------------------------------
package sobh_pkg;

   // Field widths of the configuration registers and result fields.
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int GRAD_W       = 11;
   localparam int ROW_OUT_W    = 12;
   localparam int COL_OUT_W    = 11;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ABSOLUTE_MODE = 2'd2;

   // Register reset values.
   localparam logic [CFG_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

   typedef logic [7:0] pixel_type;

   // One column of the 3x3 window, top to bottom.
   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   // Window taps and position of the current pixel.
   typedef struct packed {
      column_type                 left;
      column_type                 right;
      logic                       interior;
      logic                       last;
      logic [ROW_OUT_W-1:0]       row;
      logic [COL_OUT_W-1:0]       col;
   } window_type;

   // One result transaction.
   typedef struct packed {
      logic signed [GRAD_W-1:0]   gradient;
      logic [ROW_OUT_W-1:0]       center_row;
      logic [COL_OUT_W-1:0]       center_col;
      logic                       last_of_frame;
   } result_type;

endpackage

// ----- design/sobh_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sobh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Storage write port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ----- design/sobh_window.sv -----
// ----------------------------------------------------------------------------
// Sobel window and line stores
// Keeps the raster position, two line stores and the left window column.
// ----------------------------------------------------------------------------
module sobh_window
   import sobh_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  pixel_type               pixel,
   input  logic [CFG_WIDTH_W-1:0]  image_width,
   input  logic [CFG_HEIGHT_W-1:0] image_height,
   output window_type              window
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WSZ_W = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
   localparam int HSZ_W = (ROW_W + 1 > CFG_HEIGHT_W) ? ROW_W + 1 : CFG_HEIGHT_W;

   logic [COL_W-1:0] col_ff, col_in, read_addr;
   logic [ROW_W-1:0] row_ff, row_in;
   column_type       left_ff, left_in, mid_col_ff, mid_col_in;
   logic [WSZ_W-1:0] width_ext, eff_width, col_ext, col_plus;
   logic [HSZ_W-1:0] height_ext, eff_height, row_ext, row_plus;
   pixel_type        above_data, two_above_data;
   column_type       right_col;

   // Saturate the frame size to the supported range.
   always_comb begin
      width_ext  = WSZ_W'(image_width);
      height_ext = HSZ_W'(image_height);
      if (width_ext < WSZ_W'(3)) begin
         eff_width = WSZ_W'(3);
      end else if (width_ext > WSZ_W'(MAX_WIDTH)) begin
         eff_width = WSZ_W'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      if (height_ext < HSZ_W'(3)) begin
         eff_height = HSZ_W'(3);
      end else if (height_ext > HSZ_W'(MAX_HEIGHT)) begin
         eff_height = HSZ_W'(MAX_HEIGHT);
      end else begin
         eff_height = height_ext;
      end
   end

   // Raster position of the next pixel; wraps at the end of a row or frame.
   always_comb begin
      col_ext  = WSZ_W'(col_ff);
      row_ext  = HSZ_W'(row_ff);
      col_plus = col_ext + WSZ_W'(1);
      row_plus = row_ext + HSZ_W'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_plus >= eff_width) begin
            col_in = '0;
            if (row_plus >= eff_height) begin
               row_in = '0;
            end else begin
               row_in = row_plus[ROW_W-1:0];
            end
         end else begin
            col_in = col_plus[COL_W-1:0];
         end
      end
   end

   // The line stores are read in advance at the next pixel's column.
   assign read_addr = reset ? '0 : col_in;

   sobh_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_above (
      .clock        (clock),
      .write_enable (accept),
      .write_addr   (col_ff),
      .write_data   (pixel),
      .read_addr    (read_addr),
      .read_data    (above_data)
   );

   sobh_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_two_above (
      .clock        (clock),
      .write_enable (accept),
      .write_addr   (col_ff),
      .write_data   (above_data),
      .read_addr    (read_addr),
      .read_data    (two_above_data)
   );

   // The right column comes straight from the line stores and the new pixel.
   always_comb begin
      right_col.top = two_above_data;
      right_col.mid = above_data;
      right_col.bot = pixel;
   end

   // Shift the window by one column on each accepted pixel.
   always_comb begin
      left_in    = left_ff;
      mid_col_in = mid_col_ff;
      if (accept) begin
         left_in    = mid_col_ff;
         mid_col_in = right_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         left_ff    <= '0;
         mid_col_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         left_ff    <= left_in;
         mid_col_ff <= mid_col_in;
      end
   end

   // Interior test, end-of-frame mark and center position.
   always_comb begin
      logic [WSZ_W-1:0] center_col;
      logic [HSZ_W-1:0] center_row;
      center_col      = col_ext - WSZ_W'(1);
      center_row      = row_ext - HSZ_W'(1);
      window.left     = left_ff;
      window.right    = right_col;
      window.interior = (row_ext >= HSZ_W'(2)) && (col_ext >= WSZ_W'(2)) &&
                        (row_ext < eff_height) && (col_ext < eff_width);
      window.last     = (row_ext == eff_height - HSZ_W'(1)) &&
                        (col_ext == eff_width - WSZ_W'(1));
      window.row      = center_row[ROW_OUT_W-1:0];
      window.col      = center_col[COL_OUT_W-1:0];
   end

endmodule

// ----- design/sobh_gradient.sv -----
// ----------------------------------------------------------------------------
// Sobel horizontal gradient kernel
// Weighted right column minus weighted left column, optionally rectified.
// ----------------------------------------------------------------------------
module sobh_gradient
   import sobh_pkg::*;
(
   input  window_type               window,
   input  logic                     absolute_mode,
   output logic signed [GRAD_W-1:0] gradient
);

   logic [9:0]               sum_left, sum_right;
   logic signed [GRAD_W-1:0] diff;

   // Column sums with weights 1, 2, 1 from top to bottom.
   assign sum_left  = {2'b00, window.left.top} + {1'b0, window.left.mid, 1'b0} +
                      {2'b00, window.left.bot};
   assign sum_right = {2'b00, window.right.top} + {1'b0, window.right.mid, 1'b0} +
                      {2'b00, window.right.bot};

   assign diff = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});

   // Absolute value when requested.
   assign gradient = (absolute_mode && diff[GRAD_W-1]) ? -diff : diff;

endmodule

// ----- design/sobh_out_stage.sv -----
// ----------------------------------------------------------------------------
// Sobel result output stage
// Output register with a one-entry skid buffer behind it.
// ----------------------------------------------------------------------------
module sobh_out_stage
   import sobh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_result,
   input  logic       out_stall,
   output logic       out_valid,
   output result_type out_result,
   output logic       full
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_result_ff, out_result_in;
   result_type skid_result_ff, skid_result_in;

   // Move the skid entry or the new result forward when the output frees up.
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_result_in  = out_result_ff;
      skid_valid_in  = skid_valid_ff;
      skid_result_in = skid_result_ff;
      if (!out_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_result_in = skid_result_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = in_valid;
            out_result_in = in_result;
         end
      end else if (in_valid) begin
         skid_valid_in  = 1'b1;
         skid_result_in = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      out_result_ff  <= out_result_in;
      skid_result_ff <= skid_result_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;
   assign full       = skid_valid_ff;

endmodule

// ----- design/sobel_horizontal_gradient.sv -----
// A result is registered in the output stage (or its skid entry) from its bottom-right pixel.
// Throughput: one pixel per clock while req_stall is low; the line store RAMs are read ahead.
// The input stalls only while the output register and its skid entry are both full.
// Reset is synchronous: it clears the position counters, window and output valids,
// and restores the registers to 640 x 480, signed mode. Line stores are not cleared.
// ----------------------------------------------------------------------------
// Sobel horizontal gradient
// Streaming 3x3 horizontal Sobel filter over raster-order 8-bit pixels.
// ----------------------------------------------------------------------------
`include "sobel_horizontal_gradient_macros.svh"

module sobel_horizontal_gradient
   import sobh_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [GRAD_W-1:0] rsp_gradient,
   output logic [ROW_OUT_W-1:0]     rsp_center_row,
   output logic [COL_OUT_W-1:0]     rsp_center_col,
   output logic                     rsp_last_of_frame,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data
);

   logic [CFG_WIDTH_W-1:0]   image_width_ff, image_width_in;
   logic [CFG_HEIGHT_W-1:0]  image_height_ff, image_height_in;
   logic                     absolute_mode_ff, absolute_mode_in;
   logic                     req_accept;
   window_type               window;
   logic signed [GRAD_W-1:0] gradient;
   result_type               result, rsp_result;
   logic                     skid_full;

   // Configuration register writes.
   always_comb begin
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      absolute_mode_in = absolute_mode_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_in   = csr_write_data[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  image_height_in  = csr_write_data[CFG_HEIGHT_W-1:0];
            CSR_ABSOLUTE_MODE: absolute_mode_in = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= IMAGE_WIDTH_RESET;
         image_height_ff  <= IMAGE_HEIGHT_RESET;
         absolute_mode_ff <= 1'b0;
      end else begin
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         absolute_mode_ff <= absolute_mode_in;
      end
   end

   assign req_stall  = skid_full;
   assign req_accept = req_valid && !req_stall;

   sobh_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .pixel        (req_pixel),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .window       (window)
   );

   sobh_gradient u_gradient (
      .window        (window),
      .absolute_mode (absolute_mode_ff),
      .gradient      (gradient)
   );

   // Assemble the result transaction for an interior pixel.
   always_comb begin
      result.gradient      = gradient;
      result.center_row    = window.row;
      result.center_col    = window.col;
      result.last_of_frame = window.last;
   end

   sobh_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_accept && window.interior),
      .in_result  (result),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_result (rsp_result),
      .full       (skid_full)
   );

   assign rsp_gradient      = rsp_result.gradient;
   assign rsp_center_row    = rsp_result.center_row;
   assign rsp_center_col    = rsp_result.center_col;
   assign rsp_last_of_frame = rsp_result.last_of_frame;

   // The input stalls only behind a held result.
   `SOBH_ASSERT_IMPLY(a_stall_needs_result, clock, reset, req_stall, rsp_valid,
                      "input stalled without a pending result")
   // Results always belong to interior pixels.
   `SOBH_ASSERT_IMPLY(a_interior_position, clock, reset, rsp_valid,
                      (rsp_center_row != '0) && (rsp_center_col != '0),
                      "result at a border position")
   // The gradient stays within the kernel's range.
   `SOBH_ASSERT_IMPLY(a_gradient_range, clock, reset, rsp_valid,
                      (rsp_gradient >= -11'sd1020) && (rsp_gradient <= 11'sd1020),
                      "gradient out of range")

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel horizontal gradient testbench
// Streams raster pixels into the gradient block with random source gaps and
// sink stalls, predicts every interior result in a behavioral copy of the
// filter, and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb
   import sobh_pkg::*;
();

   localparam int          MAX_WIDTH      = 2048;
   localparam int          MAX_HEIGHT     = 4096;
   localparam int unsigned MIN_SIZE       = 3;
   localparam int unsigned RANDOM_ITEMS   = 500;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   // How busy one side of the handshake is over a stretch of transactions.
   typedef enum int unsigned {
      PACE_FULL,
      PACE_SPARSE,
      PACE_HEAVY
   } pace_type;

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_stall;
   pixel_type                req_pixel         = '0;
   logic                     rsp_valid;
   logic                     rsp_stall         = 1'b0;
   logic signed [GRAD_W-1:0] rsp_gradient;
   logic [ROW_OUT_W-1:0]     rsp_center_row;
   logic [COL_OUT_W-1:0]     rsp_center_col;
   logic                     rsp_last_of_frame;
   logic                     csr_write_enable  = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index         = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]    csr_write_data    = '0;

   // Filter state as the block should hold it.
   pixel_type   line_above     [MAX_WIDTH] = '{default: '0};
   pixel_type   line_two_above [MAX_WIDTH] = '{default: '0};
   column_type  window_left    = '0;
   column_type  window_right   = '0;
   int unsigned next_col       = 0;
   int unsigned next_row       = 0;
   int unsigned cfg_width      = IMAGE_WIDTH_RESET;
   int unsigned cfg_height     = IMAGE_HEIGHT_RESET;
   logic        cfg_absolute   = 1'b0;

   pixel_type   pending_pixels[$];
   result_type  expected_results[$];
   int unsigned src_gap        = 0;
   int unsigned sink_hold      = 0;
   pace_type    src_pace       = PACE_HEAVY;
   pace_type    sink_pace      = PACE_SPARSE;
   int unsigned idle_cycles    = 0;
   int unsigned error_count    = 0;

   sobel_horizontal_gradient i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_gradient      (rsp_gradient),
      .rsp_center_row    (rsp_center_row),
      .rsp_center_col    (rsp_center_col),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Image sizes outside the supported range are pinned to the nearest limit.
   function automatic int unsigned saturate_size(input int unsigned value,
                                                 input int unsigned limit);
      if (value < MIN_SIZE) return MIN_SIZE;
      if (value > limit) return limit;
      return value;
   endfunction

   // Wait before the next transaction; the pace itself changes now and then.
   function automatic int unsigned draw_wait(inout pace_type pace);
      if ($urandom_range(0, 63) == 0) pace = pace_type'($urandom_range(0, 2));
      case (pace)
         PACE_FULL:   return 0;
         PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
         default:     return $urandom_range(0, 15);
      endcase
   endfunction

   // Advance the filter by one pixel and queue the gradient it yields, if any.
   function automatic void predict_gradient(input pixel_type pixel);
      int unsigned width_now;
      int unsigned height_now;
      int unsigned col;
      int unsigned row;
      int unsigned addr;
      pixel_type   mid;
      pixel_type   top;
      int          grad;
      result_type  res;
      width_now  = saturate_size(cfg_width, MAX_WIDTH);
      height_now = saturate_size(cfg_height, MAX_HEIGHT);
      col  = next_col;
      row  = next_row;
      addr = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
      mid  = line_above[addr];
      top  = line_two_above[addr];
      grad = int'(top) + 2 * int'(mid) + int'(pixel)
             - int'(window_left.top) - 2 * int'(window_left.mid) - int'(window_left.bot);

      line_two_above[addr] = mid;
      line_above[addr]     = pixel;
      window_left          = window_right;
      window_right         = '{top: top, mid: mid, bot: pixel};

      // Only interior centers inside the current size produce a result.
      if (row >= 2 && col >= 2 && row < height_now && col < width_now) begin
         if (cfg_absolute && grad < 0) grad = -grad;
         res.gradient      = grad[GRAD_W-1:0];
         res.center_row    = ROW_OUT_W'(row - 1);
         res.center_col    = COL_OUT_W'(col - 1);
         res.last_of_frame = (row == height_now - 1) && (col == width_now - 1);
         expected_results.push_back(res);
      end

      // A position at or past the last column wraps once this pixel is done.
      if (col + 1 >= width_now) begin
         next_col = 0;
         next_row = (row + 1 >= height_now) ? 0 : row + 1;
      end else begin
         next_col = col + 1;
      end
   endfunction

   task automatic check_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Source side: present queued pixels, with a drawn gap after each transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_gap   <= 0;
      end else begin
         if (req_valid && !req_stall) predict_gradient(req_pixel);
         if (req_valid && req_stall) begin
            // Hold the stalled pixel as it is.
         end else if (src_gap != 0) begin
            req_valid <= 1'b0;
            src_gap   <= src_gap - 1;
         end else if (pending_pixels.size() != 0) begin
            req_pixel <= pending_pixels.pop_front();
            req_valid <= 1'b1;
            src_gap   <= draw_wait(src_pace);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Sink side: compare each result transaction and stall at random after it.
   always @(posedge clock) begin : result_monitor
      int unsigned hold;
      result_type  want;
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_hold <= 0;
      end else begin
         hold = (sink_hold > 0) ? sink_hold - 1 : 0;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display({"%0t: unexpected result, expected none, ",
                         "actual %0d row %0d col %0d last %0b"},
                        $time, rsp_gradient, rsp_center_row, rsp_center_col,
                        rsp_last_of_frame);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("gradient", want.gradient, rsp_gradient);
               check_field("center_row", want.center_row, rsp_center_row);
               check_field("center_col", want.center_col, rsp_center_col);
               check_field("last_of_frame", want.last_of_frame, rsp_last_of_frame);
            end
            hold = draw_wait(sink_pace);
         end
         sink_hold <= hold;
         rsp_stall <= (hold != 0);
      end
   end

   // Stop the run if the handshakes stop moving.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_IMAGE_WIDTH:   cfg_width    = value[CFG_WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT:  cfg_height   = value;
         CSR_ABSOLUTE_MODE: cfg_absolute = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Hold the source until every result is back and the pipeline has settled.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_pixels(input int unsigned count);
      repeat (count) pending_pixels.push_back(pixel_type'($urandom_range(0, 255)));
   endtask

   // A 3x3 frame whose left and right columns are flat; the middle is random.
   task automatic send_frame_columns(input pixel_type left, input pixel_type right);
      repeat (3) begin
         pending_pixels.push_back(left);
         pending_pixels.push_back(pixel_type'($urandom_range(0, 255)));
         pending_pixels.push_back(right);
      end
   endtask

   initial begin : stimulus
      int unsigned random_sent;
      int unsigned width_now;
      int unsigned height_now;
      int unsigned frame_pixels;
      int unsigned to_frame_end;
      int unsigned value;
      random_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset size: one full row, the wrap into the next and a few pixels more.
      send_pixels(int'(IMAGE_WIDTH_RESET) + 4);
      wait_until_drained();

      // Shrink mid-frame: the current column is past the new width and wraps.
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(3));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(3));
      pending_pixels.push_back(8'd0);
      pending_pixels.push_back(8'd255);
      pending_pixels.push_back(8'd170);
      pending_pixels.push_back(8'd85);

      // Largest rising and falling edges, signed and then absolute.
      send_frame_columns(8'd0, 8'd255);
      send_frame_columns(8'd255, 8'd0);
      wait_until_drained();
      write_register(CSR_ABSOLUTE_MODE, CSR_DATA_W'(1));
      send_frame_columns(8'd255, 8'd0);
      wait_until_drained();

      // Oversized width over part of a row, then an oversized height over narrow rows.
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(4095));
      write_register(CSR_ABSOLUTE_MODE, CSR_DATA_W'(0));
      send_pixels(64);
      wait_until_drained();
      write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(0));
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(8191));
      write_register(CSR_ABSOLUTE_MODE, CSR_DATA_W'(1));
      send_pixels(MIN_SIZE * 10);
      wait_until_drained();
      write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(4));

      // Random phases of small frames, some of them cut short mid-frame.
      while (random_sent < RANDOM_ITEMS) begin
         width_now = saturate_size(cfg_width, MAX_WIDTH);
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0:       value = $urandom_range(0, 2);
               1:       value = $urandom_range(11, 40);
               default: value = $urandom_range(3, 10);
            endcase
            // Bit 12 lies above the width register and must be ignored.
            value = value | ($urandom_range(0, 1) << CFG_WIDTH_W);
            // Mid-frame the width may only shrink, so every line store read was written.
            if ((next_col == 0 && next_row == 0) ||
                saturate_size(value[CFG_WIDTH_W-1:0], MAX_WIDTH) <= width_now)
               write_register(CSR_IMAGE_WIDTH, CSR_DATA_W'(value));
         end
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0:       value = $urandom_range(0, 2);
               1:       value = $urandom_range(7, 12);
               default: value = $urandom_range(3, 6);
            endcase
            write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'(value));
         end
         if ($urandom_range(0, 1) == 1)
            write_register(CSR_ABSOLUTE_MODE, CSR_DATA_W'($urandom_range(0, 1)));

         width_now    = saturate_size(cfg_width, MAX_WIDTH);
         height_now   = saturate_size(cfg_height, MAX_HEIGHT);
         frame_pixels = width_now * height_now;
         to_frame_end = 0;
         if (next_col != 0 || next_row != 0) begin
            to_frame_end = (next_col >= width_now) ? 1 : width_now - next_col;
            if (next_row + 1 < height_now)
               to_frame_end += (height_now - 1 - next_row) * width_now;
         end
         if ($urandom_range(0, 3) == 0) value = $urandom_range(1, frame_pixels);
         else value = to_frame_end + $urandom_range(1, 3) * frame_pixels;
         // The last phase stops at the item budget, possibly mid-frame.
         if (value > RANDOM_ITEMS - random_sent) value = RANDOM_ITEMS - random_sent;
         send_pixels(value);
         random_sent += value;
         wait_until_drained();
      end

      if (error_count == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule

// ----- sobel_horizontal_gradient.f -----
+incdir+design
design/sobh_pkg.sv
design/sobh_ram.sv
design/sobh_window.sv
design/sobh_gradient.sv
design/sobh_out_stage.sv
design/sobel_horizontal_gradient.sv
test/tb.sv
